/* rtl/psps_pkg.sv */
// shared types and constants for the preemptive sound priority scheduler
// no dependencies
`default_nettype none

package psps_pkg;

  localparam int NUM_TYPES_DEF = 32;
  localparam int TYPE_W        = 5;
  localparam int MODE_W        = 2;

  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DONE   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd3;

  typedef struct packed {
    logic load;
    logic update;
    logic pick;
  } psps_cmd_t;

endpackage

`default_nettype wire

/* rtl/preemptive_sound_priority_scheduler_unit.sv */
// top level of the preemptive sound priority scheduler
// depends on psps_pkg, psps_ctrl and psps_dpath
`default_nettype none

// One request is handled at a time and always gives exactly one result. A request
// transfer is followed by an update cycle and a pick cycle, in which the highest
// waiting repeat task starts if nothing is current; the result is then offered on the
// out_ channel. The controller takes the next request in the cycle after the result
// transfer, so requests never overlap and a held out_stall delays the next one.
// in_stall is high during reset and from a request transfer until its result has
// been transferred.
module preemptive_sound_priority_scheduler_unit #(
  parameter int NUM_TYPES = psps_pkg::NUM_TYPES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [psps_pkg::MODE_W-1:0]   in_mode,
  input  wire logic [psps_pkg::TYPE_W-1:0]   in_sound_type,
  input  wire logic                          in_repeat_req,
  input  wire logic                          in_stop_kind,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_start_valid,
  output logic [psps_pkg::TYPE_W-1:0]        out_start_type,
  output logic                               out_start_repeat,
  output logic                               out_stop_now,
  output logic                               out_stop_how,
  output logic                               out_dropped,
  output logic                               out_parked,
  output logic                               out_busy_res
);
  import psps_pkg::*;

  psps_cmd_t cmd;

  psps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  psps_dpath #(
    .NUM_TYPES (NUM_TYPES)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_mode       (in_mode),
    .in_sound_type (in_sound_type),
    .in_repeat_req (in_repeat_req),
    .in_stop_kind  (in_stop_kind),
    .start_valid   (out_start_valid),
    .start_type    (out_start_type),
    .start_repeat  (out_start_repeat),
    .stop_now      (out_stop_now),
    .stop_how      (out_stop_how),
    .dropped       (out_dropped),
    .parked        (out_parked),
    .busy_res      (out_busy_res)
  );

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> ##3 out_valid)
    else $error("result not offered three cycles after request transfer");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_start_valid) |-> out_busy_res)
    else $error("task started but no current task reported");

  a_drop_park: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_dropped && out_parked))
    else $error("request both dropped and parked");

  a_stop_how: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stop_now) |-> !out_stop_how)
    else $error("stop kind set without a stop");

endmodule

`default_nettype wire

/* rtl/psps_ctrl.sv */
// controller state machine: sequences load, update, pick and result transfer
// depends on psps_pkg
`default_nettype none

module psps_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output psps_pkg::psps_cmd_t   cmd
);
  import psps_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_PICK = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    cmd.load   = in_valid && !in_stall;
    cmd.update = (state_r == S_UPD);
    cmd.pick   = (state_r == S_PICK);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) state_nxt = S_UPD;
      end
      S_UPD:  state_nxt = S_PICK;
      S_PICK: state_nxt = S_OUT;
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/psps_dpath.sv */
// datapath: current task, waiting bitmap, priority encoder and result registers
// depends on psps_pkg
`default_nettype none

module psps_dpath #(
  parameter int NUM_TYPES = psps_pkg::NUM_TYPES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire psps_pkg::psps_cmd_t           cmd,
  input  wire logic [psps_pkg::MODE_W-1:0]   in_mode,
  input  wire logic [psps_pkg::TYPE_W-1:0]   in_sound_type,
  input  wire logic                          in_repeat_req,
  input  wire logic                          in_stop_kind,
  output logic                               start_valid,
  output logic [psps_pkg::TYPE_W-1:0]        start_type,
  output logic                               start_repeat,
  output logic                               stop_now,
  output logic                               stop_how,
  output logic                               dropped,
  output logic                               parked,
  output logic                               busy_res
);
  import psps_pkg::*;

  localparam int IDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

  logic [NUM_TYPES-1:0] map_r, map_nxt;
  logic                 cur_valid_r, cur_valid_nxt;
  logic [TYPE_W-1:0]    cur_type_r, cur_type_nxt;
  logic                 cur_rep_r, cur_rep_nxt;

  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [TYPE_W-1:0]    type_r, type_nxt;
  logic                 rep_r, rep_nxt;
  logic                 kind_r, kind_nxt;

  logic                 sv_r, sv_nxt;
  logic [TYPE_W-1:0]    st_r, st_nxt;
  logic                 sr_r, sr_nxt;
  logic                 sn_r, sn_nxt;
  logic                 sh_r, sh_nxt;
  logic                 dr_r, dr_nxt;
  logic                 pk_r, pk_nxt;

  logic                 in_range;
  logic [NUM_TYPES-1:0] req_bit;
  logic [NUM_TYPES-1:0] cur_bit;
  logic [IDX_W-1:0]     top_idx;
  logic [NUM_TYPES-1:0] top_bit;

  assign in_range = (32'(type_r) < NUM_TYPES);
  assign req_bit  = NUM_TYPES'(1) << type_r;
  assign cur_bit  = NUM_TYPES'(1) << cur_type_r;
  assign top_bit  = NUM_TYPES'(1) << top_idx;

  // highest waiting type
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NUM_TYPES; i++) begin
      if (map_r[i]) top_idx = IDX_W'(i);
    end
  end

  always_comb begin
    map_nxt       = map_r;
    cur_valid_nxt = cur_valid_r;
    cur_type_nxt  = cur_type_r;
    cur_rep_nxt   = cur_rep_r;
    mode_nxt      = mode_r;
    type_nxt      = type_r;
    rep_nxt       = rep_r;
    kind_nxt      = kind_r;
    sv_nxt        = sv_r;
    st_nxt        = st_r;
    sr_nxt        = sr_r;
    sn_nxt        = sn_r;
    sh_nxt        = sh_r;
    dr_nxt        = dr_r;
    pk_nxt        = pk_r;

    if (cmd.load) begin
      mode_nxt = in_mode;
      type_nxt = in_sound_type;
      rep_nxt  = in_repeat_req;
      kind_nxt = in_stop_kind;
      sv_nxt   = 1'b0;
      st_nxt   = '0;
      sr_nxt   = 1'b0;
      sn_nxt   = 1'b0;
      sh_nxt   = 1'b0;
      dr_nxt   = 1'b0;
      pk_nxt   = 1'b0;
    end else if (cmd.update) begin
      unique case (mode_r)
        MODE_ADD: begin
          if (in_range) begin
            if (cur_valid_r && (cur_type_r >= type_r)) begin
              if (rep_r) begin
                map_nxt = map_r | req_bit;
                pk_nxt  = 1'b1;
              end else begin
                dr_nxt = 1'b1;
              end
            end else begin
              if (cur_valid_r) begin
                if (cur_rep_r) begin
                  map_nxt = map_r | cur_bit;
                  pk_nxt  = 1'b1;
                end
                sn_nxt = 1'b1;
                sh_nxt = 1'b0;
              end
              cur_valid_nxt = 1'b1;
              cur_type_nxt  = type_r;
              cur_rep_nxt   = rep_r;
              sv_nxt        = 1'b1;
              st_nxt        = type_r;
              sr_nxt        = rep_r;
            end
          end
        end
        MODE_REMOVE: begin
          if (in_range) begin
            map_nxt = map_r & ~req_bit;
            if (cur_valid_r && (cur_type_r == type_r)) begin
              sn_nxt        = 1'b1;
              sh_nxt        = kind_r;
              cur_valid_nxt = 1'b0;
              cur_type_nxt  = '0;
              cur_rep_nxt   = 1'b0;
            end
          end
        end
        MODE_DONE: begin
          if (in_range && cur_valid_r && (cur_type_r == type_r)) begin
            cur_valid_nxt = 1'b0;
            cur_type_nxt  = '0;
            cur_rep_nxt   = 1'b0;
          end
        end
        MODE_FLUSH: begin
          map_nxt = '0;
          if (cur_valid_r) begin
            sn_nxt = 1'b1;
            sh_nxt = 1'b0;
          end
          cur_valid_nxt = 1'b0;
          cur_type_nxt  = '0;
          cur_rep_nxt   = 1'b0;
        end
        default: ;
      endcase
    end else if (cmd.pick) begin
      if (!cur_valid_r && (map_r != '0)) begin
        map_nxt       = map_r & ~top_bit;
        cur_valid_nxt = 1'b1;
        cur_type_nxt  = TYPE_W'(top_idx);
        cur_rep_nxt   = 1'b1;
        sv_nxt        = 1'b1;
        st_nxt        = TYPE_W'(top_idx);
        sr_nxt        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r       <= '0;
      cur_valid_r <= 1'b0;
      cur_type_r  <= '0;
      cur_rep_r   <= 1'b0;
    end else begin
      map_r       <= map_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_type_r  <= cur_type_nxt;
      cur_rep_r   <= cur_rep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    type_r <= type_nxt;
    rep_r  <= rep_nxt;
    kind_r <= kind_nxt;
    sv_r   <= sv_nxt;
    st_r   <= st_nxt;
    sr_r   <= sr_nxt;
    sn_r   <= sn_nxt;
    sh_r   <= sh_nxt;
    dr_r   <= dr_nxt;
    pk_r   <= pk_nxt;
  end

  assign start_valid  = sv_r;
  assign start_type   = st_r;
  assign start_repeat = sr_r;
  assign stop_now     = sn_r;
  assign stop_how     = sh_r;
  assign dropped      = dr_r;
  assign parked       = pk_r;
  assign busy_res     = cur_valid_r;

endmodule

`default_nettype wire
